>>> rtl/dtu_pkg.sv
// Package for the DVB text to UTF-8 converter: table modes, result kinds,
// character constants and the Latin-5 to Unicode map.
// No dependencies.
`default_nettype none

package dtu_pkg;

    localparam int ByteW  = 8;
    localparam int KindW  = 2;
    localparam int MaxRes = 3;
    localparam int CntW   = 2;   // holds 0 .. MaxRes
    localparam int CodeW  = 9;   // Latin-5 code points stay below 0x200

    typedef enum logic [1:0] {
        MODE_DROP    = 2'd0,
        MODE_DEFAULT = 2'd1,
        MODE_UTF8    = 2'd2,
        MODE_LATIN5  = 2'd3
    } mode_t;

    typedef enum logic [KindW-1:0] {
        KIND_DATA  = 2'd0,
        KIND_TERM  = 2'd1,
        KIND_ERROR = 2'd2
    } kind_t;

    localparam logic [ByteW-1:0] SEL_UTF8    = 8'h15;
    localparam logic [ByteW-1:0] SEL_LATIN5  = 8'h05;
    localparam logic [ByteW-1:0] FIRST_PRINT = 8'h20;
    localparam logic [ByteW-1:0] CTRL_LO     = 8'h80;
    localparam logic [ByteW-1:0] CTRL_HI     = 8'h9F;
    localparam logic [ByteW-1:0] CTRL_NL     = 8'h8A;
    localparam logic [ByteW-1:0] LINE_FEED   = 8'h0A;
    localparam logic [ByteW-1:0] LEAD2       = 8'hC0;
    localparam logic [ByteW-1:0] CONT        = 8'h80;

    // Latin-5 differs from Latin-1 in six places only.
    function automatic logic [CodeW-1:0] latin5_code(input logic [ByteW-1:0] b);
        logic [CodeW-1:0] c;
        begin
            unique case (b)
                8'hD0:   c = 9'h11E;
                8'hDD:   c = 9'h130;
                8'hDE:   c = 9'h15E;
                8'hF0:   c = 9'h11F;
                8'hFD:   c = 9'h131;
                8'hFE:   c = 9'h15F;
                default: c = {1'b0, b};
            endcase
            return c;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/dvb_text_to_utf8.sv
// Top level of the DVB text to UTF-8 converter.
// Depends on dtu_pkg.
//
// Usage: raw text bytes enter on the s_ channel, one byte per word, with
// s_tuser set on the first byte of a string (the table selector) and s_tlast
// on its final byte. UTF-8 bytes leave on the m_ channel, one byte per word;
// m_tuser gives the kind (data, terminator, unsupported table) and m_tlast
// marks the final word caused by one input byte.
// Path: a byte is held in an input register, and its results are then
// built into a group register of up to three words, from which the result
// words are presented in order.
// Throughput: one input byte per cycle while each gives at most one result
// and the receiver does not stall; an input byte that gives several results
// occupies the output for each of its words, so a two-byte Latin-5 character
// ending a string occupies it for three words. The single output channel sets that limit.
// Reset puts the converter into the dropping mode, so bytes before the first
// string start give nothing, and empties both registers.
// When the receiver stalls, the group register holds its word and the input
// register fills; s_tready then falls until the group drains.
`default_nettype none

module dvb_text_to_utf8 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [dtu_pkg::ByteW-1:0]  s_tdata,   // [7:0] text_byte
    input  wire logic                       s_tuser,   // [0] string_start
    input  wire logic                       s_tlast,   // string_end
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [dtu_pkg::ByteW-1:0]       m_tdata,   // [7:0] out_byte
    output logic [dtu_pkg::KindW-1:0]       m_tuser,   // [1:0] kind
    output logic                            m_tlast    // run_last
);
    import dtu_pkg::*;

    // Input register
    logic             in_valid_reg;
    logic [ByteW-1:0] in_byte_reg;
    logic             in_start_reg;
    logic             in_end_reg;

    // Result group register
    logic             grp_valid_reg;
    logic [ByteW-1:0] grp_byte_reg [MaxRes];
    kind_t            grp_kind_reg [MaxRes];
    logic [CntW-1:0]  grp_cnt_reg;
    logic [CntW-1:0]  grp_idx_reg;

    mode_t            mode_reg, mode_next;

    logic             grp_last;
    logic             grp_free;
    logic             grp_load;

    logic [ByteW-1:0] res_byte [MaxRes];
    kind_t            res_kind [MaxRes];
    logic [CntW-1:0]  res_cnt;

    assign grp_last = (grp_idx_reg == grp_cnt_reg - CntW'(1));
    assign grp_free = !grp_valid_reg || (m_tready && grp_last);
    assign grp_load = in_valid_reg && grp_free;
    assign s_tready = !in_valid_reg || grp_free;

    assign m_tvalid = grp_valid_reg;
    assign m_tdata  = grp_byte_reg[grp_idx_reg];
    assign m_tuser  = grp_kind_reg[grp_idx_reg];
    assign m_tlast  = grp_last;

    // Results of the byte in the input register under the current mode.
    always_comb
    begin
        logic             emit;
        mode_t            cmode;
        logic [CodeW-1:0] code;
        logic             is_ctrl;
        emit      = 1'b0;
        cmode     = mode_reg;
        mode_next = mode_reg;
        res_cnt   = '0;
        for (int i = 0; i < MaxRes; i++)
        begin
            res_byte[i] = '0;
            res_kind[i] = KIND_DATA;
        end

        if (in_start_reg)
        begin
            if (in_byte_reg == SEL_UTF8)
                cmode = MODE_UTF8;
            else if (in_byte_reg == SEL_LATIN5)
                cmode = MODE_LATIN5;
            else if (in_byte_reg >= FIRST_PRINT)
            begin
                cmode = MODE_DEFAULT;
                emit  = 1'b1;
            end
            else
                cmode = MODE_DROP;
        end
        else
            emit = (mode_reg != MODE_DROP);

        code    = latin5_code(in_byte_reg);
        is_ctrl = (in_byte_reg >= CTRL_LO) && (in_byte_reg <= CTRL_HI);

        if (emit)
        begin
            if (cmode == MODE_UTF8)
            begin
                res_byte[0] = in_byte_reg;
                res_cnt     = CntW'(1);
            end
            else if (is_ctrl)
            begin
                if (in_byte_reg == CTRL_NL)
                begin
                    res_byte[0] = LINE_FEED;
                    res_cnt     = CntW'(1);
                end
            end
            else if (cmode == MODE_LATIN5 && code >= CodeW'(CONT))
            begin
                // Two-byte UTF-8 sequence.
                res_byte[0] = LEAD2 | {5'b00000, code[CodeW-1:6]};
                res_byte[1] = CONT  | {2'b00, code[5:0]};
                res_cnt     = CntW'(2);
            end
            else
            begin
                res_byte[0] = in_byte_reg;
                res_cnt     = CntW'(1);
            end
        end

        mode_next = cmode;
        if (in_start_reg && cmode == MODE_DROP)
        begin
            res_kind[0] = KIND_ERROR;
            res_cnt     = CntW'(1);
        end
        else if (in_end_reg && cmode != MODE_DROP)
        begin
            res_kind[res_cnt] = KIND_TERM;
            res_byte[res_cnt] = '0;
            res_cnt           = res_cnt + CntW'(1);
            mode_next         = MODE_DROP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            grp_valid_reg <= 1'b0;
            grp_idx_reg   <= '0;
            grp_cnt_reg   <= '0;
            mode_reg      <= MODE_DROP;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;

            if (grp_load)
            begin
                mode_reg      <= mode_next;
                grp_valid_reg <= (res_cnt != '0);
                grp_cnt_reg   <= res_cnt;
                grp_idx_reg   <= '0;
            end
            else if (grp_free)
                grp_valid_reg <= 1'b0;
            else if (m_tready)
                grp_idx_reg <= grp_idx_reg + CntW'(1);
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
            in_end_reg   <= s_tlast;
        end
        if (grp_load)
        begin
            grp_byte_reg <= res_byte;
            grp_kind_reg <= res_kind;
        end
    end

    // The index must always point at a loaded word of the group.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (grp_idx_reg < grp_cnt_reg))
        else $error("result index beyond group");

    // An unsupported-table word is always the only and final word of its byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_ERROR) |-> (m_tlast && grp_cnt_reg == CntW'(1)))
        else $error("error word not alone");

    // A terminator closes its group and leaves the converter dropping.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_TERM) |-> (m_tlast && mode_reg == MODE_DROP))
        else $error("terminator misplaced");

endmodule

`default_nettype wire
